>>> rtl/sts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for signed_to_seven_segment.
// No dependencies.
package sts_pkg;

	localparam int IN_W   = 16;
	localparam int MAG_W  = 15;
	localparam int NUM_POS = 5;
	localparam int BCD_W  = 4 * NUM_POS;
	localparam int SEG_W  = 7;
	localparam int OUT_DATA_W = 40;

	localparam logic [SEG_W-1:0] MINUS_SEG = 7'h40;
	localparam logic [SEG_W-1:0] BLANK_SEG = 7'h00;
	localparam logic [IN_W-1:0]  MOST_NEG  = 16'h8000;
	localparam logic [MAG_W-1:0] MAG_MAX   = 15'h7FFF;

	typedef logic [SEG_W-1:0] seg_t;

	// binary-to-BCD working word: BCD digits plus the binary bits not yet shifted in
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [MAG_W-1:0] bin;
	} dd_t;

	function automatic seg_t digit_seg(input logic [3:0] d);
		seg_t s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = BLANK_SEG;
		endcase
		return s;
	endfunction

	// up to four shift-add-3 steps
	function automatic dd_t dabble(input dd_t w, input int steps);
		dd_t r;
		r = w;
		for (int i = 0; i < 4; i++) begin
			if (i < steps) begin
				for (int k = 0; k < NUM_POS; k++) begin
					if (r.bcd[4*k +: 4] >= 4'd5)
						r.bcd[4*k +: 4] = r.bcd[4*k +: 4] + 4'd3;
				end
				r.bcd = {r.bcd[BCD_W-2:0], r.bin[MAG_W-1]};
				r.bin = {r.bin[MAG_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/signed_to_seven_segment.sv
`timescale 1ns / 1ps
// Signed 16-bit number to five seven-segment patterns, six-stage pipeline.
// Depends on sts_pkg.
//
// Every input word gives one output word; a new word is accepted every cycle
// while the output side is ready. The pipeline has one stage for the magnitude,
// four stages of shift-add-3 binary-to-BCD conversion (four bits, the last three),
// one stage for blanking, sign placement and segment lookup. Each stage stalls on
// its own, so bubbles are squeezed out while the output waits. -32768 shows as
// 32767 with the saturated and sign_dropped flags set.
module signed_to_seven_segment (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [sts_pkg::IN_W-1:0]       s_axis_tdata,  // value[15:0]
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// seg_pos1[6:0], seg_pos2[13:7], seg_pos3[20:14], seg_pos4[27:21],
	// seg_pos5[34:28], sign_dropped[35], saturated[36], zero[39:37]
	output logic [sts_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	sts_pkg::dd_t dd_s1, dd_s2, dd_s3, dd_s4, dd_s5;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic sat_s1, sat_s2, sat_s3, sat_s4, sat_s5;

	sts_pkg::seg_t seg_s6 [sts_pkg::NUM_POS];
	logic dropped_s6, sat_s6;

	assign en_s6 = !v_s6 || m_axis_tready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// stage 1: magnitude with clamp
	logic [sts_pkg::IN_W-1:0] neg_val;
	assign neg_val = 16'h0000 - s_axis_tdata;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			neg_s1 <= s_axis_tdata[sts_pkg::IN_W-1];
			sat_s1 <= (s_axis_tdata == sts_pkg::MOST_NEG);
			dd_s1.bcd <= '0;
			if (s_axis_tdata == sts_pkg::MOST_NEG)
				dd_s1.bin <= sts_pkg::MAG_MAX;
			else if (s_axis_tdata[sts_pkg::IN_W-1])
				dd_s1.bin <= neg_val[sts_pkg::MAG_W-1:0];
			else
				dd_s1.bin <= s_axis_tdata[sts_pkg::MAG_W-1:0];
		end
	end

	// stages 2..5: binary to BCD, 4+4+4+3 steps
	always_ff @(posedge clk) begin
		if (en_s2) begin
			dd_s2  <= sts_pkg::dabble(dd_s1, 4);
			neg_s2 <= neg_s1;
			sat_s2 <= sat_s1;
		end
		if (en_s3) begin
			dd_s3  <= sts_pkg::dabble(dd_s2, 4);
			neg_s3 <= neg_s2;
			sat_s3 <= sat_s2;
		end
		if (en_s4) begin
			dd_s4  <= sts_pkg::dabble(dd_s3, 4);
			neg_s4 <= neg_s3;
			sat_s4 <= sat_s3;
		end
		if (en_s5) begin
			dd_s5  <= sts_pkg::dabble(dd_s4, 3);
			neg_s5 <= neg_s4;
			sat_s5 <= sat_s4;
		end
	end

	// stage 6: blanking, minus placement, segment lookup
	logic [3:0]    dig   [sts_pkg::NUM_POS];
	logic          lead  [sts_pkg::NUM_POS];
	sts_pkg::seg_t seg_c [sts_pkg::NUM_POS];
	logic          dropped_c;

	always_comb begin
		for (int i = 0; i < sts_pkg::NUM_POS; i++)
			dig[i] = dd_s5.bcd[4*(sts_pkg::NUM_POS-1-i) +: 4];
		// lead[i]: position i is a leading zero, shown blank or as the minus; rightmost never blanked
		lead[0] = (dig[0] == 4'd0);
		for (int i = 1; i < sts_pkg::NUM_POS - 1; i++)
			lead[i] = lead[i-1] && (dig[i] == 4'd0);
		lead[sts_pkg::NUM_POS-1] = 1'b0;
		for (int i = 0; i < sts_pkg::NUM_POS; i++) begin
			if (lead[i]) begin
				if (neg_s5 && !lead[i+1 < sts_pkg::NUM_POS ? i+1 : i])
					seg_c[i] = sts_pkg::MINUS_SEG;
				else
					seg_c[i] = sts_pkg::BLANK_SEG;
			end else begin
				seg_c[i] = sts_pkg::digit_seg(dig[i]);
			end
		end
		dropped_c = neg_s5 && !lead[0];
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			for (int i = 0; i < sts_pkg::NUM_POS; i++)
				seg_s6[i] <= seg_c[i];
			dropped_s6 <= dropped_c;
			sat_s6     <= sat_s5;
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {3'b000, sat_s6, dropped_s6,
		seg_s6[4], seg_s6[3], seg_s6[2], seg_s6[1], seg_s6[0]};

	// a clamped input always fills all five positions
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[36] |-> m_axis_tdata[35])
		else $error("saturated without sign_dropped");

	// a dropped sign means the leftmost position holds a digit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[35] |-> m_axis_tdata[6:0] != sts_pkg::BLANK_SEG &&
			m_axis_tdata[6:0] != sts_pkg::MINUS_SEG)
		else $error("sign_dropped with free leftmost position");

	// rightmost position always shows a digit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[34:28] != sts_pkg::BLANK_SEG &&
			m_axis_tdata[34:28] != sts_pkg::MINUS_SEG)
		else $error("rightmost position not a digit");

	// a stage holding a word while the next one stalls keeps it
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !en_s6 |=> v_s5 && $stable(dd_s5))
		else $error("stage 5 word lost during stall");

endmodule
